// File: design/rm2q_pkg.sv
// rm2q_pkg: payload types and branch codes for the rotation matrix to quaternion block.
// No dependencies.
package rm2q_pkg;

  typedef struct packed {
    logic signed [15:0] col0_x;
    logic signed [15:0] col0_y;
    logic signed [15:0] col0_z;
    logic signed [15:0] col1_x;
    logic signed [15:0] col1_y;
    logic signed [15:0] col1_z;
    logic signed [15:0] col2_x;
    logic signed [15:0] col2_y;
    logic signed [15:0] col2_z;
  } mat_t;

  typedef struct packed {
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic [1:0]         branch_taken;
    logic               radicand_clamped;
  } quat_t;

  localparam logic [1:0] BR_TRACE = 2'd0;
  localparam logic [1:0] BR_X     = 2'd1;
  localparam logic [1:0] BR_Y     = 2'd2;
  localparam logic [1:0] BR_Z     = 2'd3;

  // side data carried with every item: three 17-bit sums or differences, branch, clamp flag
  localparam int SIDE_W = 3 * 17 + 3;

endpackage

// File: design/rm2q_front.sv
// rm2q_front: classifies one matrix item (branch select, radicand, off-diagonal sums and differences).
// Depends on rm2q_pkg.
module rm2q_front import rm2q_pkg::*; #(
  parameter int FRAC_BITS = 14,
  parameter int RW        = 18
) (
  input  mat_t                   mat,
  output logic [RW-1:0]          rad,
  output logic signed [16:0]     d0,
  output logic signed [16:0]     d1,
  output logic signed [16:0]     d2,
  output logic [1:0]             branch,
  output logic                   clamped
);

  function automatic logic signed [16:0] sum17(input logic signed [15:0] a,
                                               input logic signed [15:0] b,
                                               input logic sub);
    logic signed [16:0] ea;
    logic signed [16:0] eb;
    ea = {a[15], a};
    eb = {b[15], b};
    return sub ? (ea - eb) : (ea + eb);
  endfunction

  logic signed [RW:0] e00, e11, e22, one, r;
  logic signed [17:0] trace;

  always_comb begin
    e00   = {{(RW - 15){mat.col0_x[15]}}, mat.col0_x};
    e11   = {{(RW - 15){mat.col1_y[15]}}, mat.col1_y};
    e22   = {{(RW - 15){mat.col2_z[15]}}, mat.col2_z};
    one   = {{RW{1'b0}}, 1'b1} << FRAC_BITS;
    trace = {{2{mat.col0_x[15]}}, mat.col0_x} + {{2{mat.col1_y[15]}}, mat.col1_y}
          + {{2{mat.col2_z[15]}}, mat.col2_z};
    priority if (trace > 0) begin
      branch = BR_TRACE;
      r  = one + e00 + e11 + e22;
      d0 = sum17(mat.col1_z, mat.col2_y, 1'b1);
      d1 = sum17(mat.col2_x, mat.col0_z, 1'b1);
      d2 = sum17(mat.col0_y, mat.col1_x, 1'b1);
    end else if (mat.col0_x > mat.col1_y && mat.col0_x > mat.col2_z) begin
      branch = BR_X;
      r  = one + e00 - e11 - e22;
      d0 = sum17(mat.col1_x, mat.col0_y, 1'b0);
      d1 = sum17(mat.col2_x, mat.col0_z, 1'b0);
      d2 = sum17(mat.col1_z, mat.col2_y, 1'b1);
    end else if (mat.col1_y > mat.col2_z) begin
      branch = BR_Y;
      r  = one + e11 - e00 - e22;
      d0 = sum17(mat.col1_x, mat.col0_y, 1'b0);
      d1 = sum17(mat.col2_y, mat.col1_z, 1'b0);
      d2 = sum17(mat.col2_x, mat.col0_z, 1'b1);
    end else begin
      branch = BR_Z;
      r  = one + e22 - e00 - e11;
      d0 = sum17(mat.col2_x, mat.col0_z, 1'b0);
      d1 = sum17(mat.col2_y, mat.col1_z, 1'b0);
      d2 = sum17(mat.col0_y, mat.col1_x, 1'b1);
    end
    // non-positive radicand: clamp to one LSB
    clamped = (r <= 0);
    rad     = clamped ? {{(RW - 1){1'b0}}, 1'b1} : r[RW-1:0];
  end

endmodule

// File: design/rm2q_queue.sv
// rm2q_queue: two-entry queue between the classify front and the arithmetic back.
// Depends on rm2q_pkg (import only for house consistency of types).
module rm2q_queue import rm2q_pkg::*; #(
  parameter int W = 72
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] mem [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         push, pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count above depth");
  a_fill: assert property (@(posedge clk) disable iff (rst)
      push && !pop |=> count == $past(count) + 2'd1)
    else $error("queue count missed a push");
  a_drain: assert property (@(posedge clk) disable iff (rst)
      pop && !push |=> count == $past(count) - 2'd1)
    else $error("queue count missed a pop");
  a_ptrs: assert property (@(posedge clk) disable iff (rst)
      (count == 2'd0 || count == 2'd2) |-> wr_ptr == rd_ptr)
    else $error("queue pointers out of step");

endmodule

// File: design/rm2q_back.sv
// rm2q_back: pipelined square root, three pipelined dividers and output formatting.
// Depends on rm2q_pkg.
module rm2q_back import rm2q_pkg::*; #(
  parameter int FRAC_BITS = 14,
  parameter int RW        = 18
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              src_valid,
  output logic              src_ready,
  input  logic [RW-1:0]     rad,
  input  logic [SIDE_W-1:0] side,
  output logic              quat_valid,
  input  logic              quat_ready,
  output quat_t             quat
);

  localparam int NB = (RW + FRAC_BITS + 1) / 2;   // root bits = sqrt steps
  localparam int SW = NB;
  localparam int NUMW = 18 + FRAC_BITS;
  localparam int CW = (NUMW > SW + 17) ? NUMW : SW + 17;

  function automatic logic [15:0] fmt(input logic neg, input logic ovf,
                                      input logic [15:0] q);
    logic big;
    big = ovf | q[15];
    if (!neg) return big ? 16'h7fff : q;
    return big ? 16'h8000 : (~q + 16'd1);
  endfunction

  logic adv;
  assign adv       = !quat_valid || quat_ready;
  assign src_ready = adv;

  // ---------------- square root pipeline ----------------
  logic              sv    [0:NB];
  logic [SW:0]       srem  [0:NB];
  logic [SW-1:0]     sroot [0:NB];
  logic [2*NB-1:0]   sn    [0:NB];
  logic [SIDE_W-1:0] sd    [0:NB];

  always_ff @(posedge clk) begin
    if (rst) sv[0] <= 1'b0;
    else if (adv) sv[0] <= src_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      srem[0]  <= '0;
      sroot[0] <= '0;
      sn[0]    <= {{(2 * NB - RW){1'b0}}, rad} << FRAC_BITS;
      sd[0]    <= side;
    end
  end

  for (genvar k = 0; k < NB; k++) begin : g_sqrt
    logic [SW+2:0] t, tr, nrem;
    logic          ge;
    always_comb begin
      t    = {srem[k], sn[k][2*NB-1 -: 2]};
      tr   = {1'b0, sroot[k], 2'b01};
      ge   = (t >= tr);
      nrem = ge ? (t - tr) : t;
    end
    always_ff @(posedge clk) begin
      if (rst) sv[k+1] <= 1'b0;
      else if (adv) sv[k+1] <= sv[k];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        srem[k+1]  <= nrem[SW:0];
        sroot[k+1] <= {sroot[k][SW-2:0], ge};
        sn[k+1]    <= sn[k] << 2;
        sd[k+1]    <= sd[k];
      end
    end
  end

  // ---------------- divider pipelines ----------------
  logic          dv   [0:16];
  logic [CW-1:0] drem [0:16][3];
  logic [15:0]   dq   [0:16][3];
  logic          dneg [0:16][3];
  logic          dovf [0:16][3];
  logic [SW-1:0] ds   [0:16];
  logic [2:0]    dsb  [0:16];

  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else if (adv) dv[0] <= sv[NB];
  end

  for (genvar i = 0; i < 3; i++) begin : g_prep
    logic signed [16:0] d;
    logic [16:0]        mag;
    logic [CW-1:0]      numx, lim;
    always_comb begin
      d    = sd[NB][SIDE_W-1-17*i -: 17];
      mag  = d[16] ? (~d + 17'd1) : d;
      numx = ({{(CW - 17){1'b0}}, mag} << FRAC_BITS) + {{(CW - SW){1'b0}}, sroot[NB]};
      lim  = {{(CW - SW){1'b0}}, sroot[NB]} << 17;
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        drem[0][i] <= numx;
        dq[0][i]   <= '0;
        dneg[0][i] <= d[16];
        dovf[0][i] <= (numx >= lim);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ds[0]  <= sroot[NB];
      dsb[0] <= sd[NB][2:0];
    end
  end

  for (genvar t = 0; t < 16; t++) begin : g_div
    logic [CW-1:0] den;
    assign den = {{(CW - SW - 1){1'b0}}, ds[t], 1'b0} << (15 - t);
    always_ff @(posedge clk) begin
      if (rst) dv[t+1] <= 1'b0;
      else if (adv) dv[t+1] <= dv[t];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        ds[t+1]  <= ds[t];
        dsb[t+1] <= dsb[t];
      end
    end
    for (genvar i = 0; i < 3; i++) begin : g_lane
      logic ge;
      assign ge = (drem[t][i] >= den);
      always_ff @(posedge clk) begin
        if (adv) begin
          drem[t+1][i] <= ge ? (drem[t][i] - den) : drem[t][i];
          dq[t+1][i]   <= {dq[t][i][14:0], ge};
          dneg[t+1][i] <= dneg[t][i];
          dovf[t+1][i] <= dovf[t][i];
        end
      end
    end
  end

  // ---------------- output formatting ----------------
  logic [SW+16:0] bx;
  logic [15:0]    big, c0, c1, c2;
  quat_t          res;

  always_comb begin
    bx  = ({17'd0, ds[16]} + {{(SW + 16){1'b0}}, 1'b1}) >> 1;
    big = (bx > {{(SW + 1){1'b0}}, 16'h7fff}) ? 16'h7fff : bx[15:0];
    c0  = fmt(dneg[16][0], dovf[16][0], dq[16][0]);
    c1  = fmt(dneg[16][1], dovf[16][1], dq[16][1]);
    c2  = fmt(dneg[16][2], dovf[16][2], dq[16][2]);
    res.branch_taken     = dsb[16][2:1];
    res.radicand_clamped = dsb[16][0];
    unique case (dsb[16][2:1])
      BR_TRACE: begin
        res.quat_x = c0;  res.quat_y = c1;  res.quat_z = c2;  res.quat_w = big;
      end
      BR_X: begin
        res.quat_x = big; res.quat_y = c0;  res.quat_z = c1;  res.quat_w = c2;
      end
      BR_Y: begin
        res.quat_x = c0;  res.quat_y = big; res.quat_z = c1;  res.quat_w = c2;
      end
      default: begin
        res.quat_x = c0;  res.quat_y = c1;  res.quat_z = big; res.quat_w = c2;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) quat_valid <= 1'b0;
    else if (adv) quat_valid <= dv[16];
  end
  always_ff @(posedge clk) begin
    if (adv) quat <= res;
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
      quat_valid && !quat_ready |=> quat_valid && $stable(quat))
    else $error("result changed while stalled");
  a_flow: assert property (@(posedge clk) disable iff (rst)
      adv && dv[16] |=> quat_valid)
    else $error("finished item lost at output");
  a_stall: assert property (@(posedge clk) disable iff (rst)
      !adv |=> $stable(dv[0]) && $stable(sv[0]))
    else $error("pipeline moved during stall");

endmodule

// File: design/rotation_matrix_to_quaternion.sv
// rotation_matrix_to_quaternion: top level, Shepperd matrix to quaternion converter.
// Depends on rm2q_pkg, rm2q_front, rm2q_queue, rm2q_back.
//
//  channel  | valid       | ready       | payload
//  ---------+-------------+-------------+-----------------------------------
//  matrix   | mat_valid   | mat_ready   | mat  (mat_t, nine Q1.14 elements)
//  result   | quat_valid  | quat_ready  | quat (quat_t, x y z w, branch, flag)
//
// One item per cycle sustained while quat_ready stays high. Results pass the queue, the
// square root pipeline of NB = (RW + FRAC_BITS + 1) / 2 root bits (one root bit a
// stage), the 16-stage dividers and the registered output.
// Reset (rst, synchronous) empties the queue and all pipeline valid bits.
// A stalled result freezes the back pipeline; the two-entry queue keeps taking
// items until it fills, then mat_ready drops.
module rotation_matrix_to_quaternion import rm2q_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  mat_valid,
  output logic  mat_ready,
  input  mat_t  mat,
  output logic  quat_valid,
  input  logic  quat_ready,
  output quat_t quat
);

  // radicand width: 1.0 plus three diagonal terms
  localparam int RW = (FRAC_BITS >= 17) ? FRAC_BITS + 1 : 18;
  localparam int QW = RW + SIDE_W;

  logic [RW-1:0]      f_rad;
  logic signed [16:0] f_d0, f_d1, f_d2;
  logic [1:0]         f_branch;
  logic               f_clamped;
  logic [QW-1:0]      q_in, q_out;
  logic               q_valid, q_ready;

  rm2q_front #(.FRAC_BITS(FRAC_BITS), .RW(RW)) u_front (
    .mat     (mat),
    .rad     (f_rad),
    .d0      (f_d0),
    .d1      (f_d1),
    .d2      (f_d2),
    .branch  (f_branch),
    .clamped (f_clamped)
  );

  assign q_in = {f_rad, f_d0, f_d1, f_d2, f_branch, f_clamped};

  rm2q_queue #(.W(QW)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (mat_valid),
    .push_ready (mat_ready),
    .push_data  (q_in),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_out)
  );

  rm2q_back #(.FRAC_BITS(FRAC_BITS), .RW(RW)) u_back (
    .clk        (clk),
    .rst        (rst),
    .src_valid  (q_valid),
    .src_ready  (q_ready),
    .rad        (q_out[QW-1 -: RW]),
    .side       (q_out[SIDE_W-1:0]),
    .quat_valid (quat_valid),
    .quat_ready (quat_ready),
    .quat       (quat)
  );

endmodule

// File: dv/tb_rotation_matrix_to_quaternion.sv
// Testbench for rotation_matrix_to_quaternion: directed and random matrices,
// checked against an in-bench Shepperd fixed-point predictor. Depends on rm2q_pkg.
`timescale 1ns / 1ps

module tb_rotation_matrix_to_quaternion;
  import rm2q_pkg::*;

  localparam int FB = 14;
  localparam longint ONE = 64'sd1 << FB;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  mat_valid = 1'b0;
  logic  mat_ready;
  mat_t  mat = '0;
  logic  quat_valid;
  logic  quat_ready = 1'b0;
  quat_t quat;

  // expected quaternions in order of acceptance
  quat_t quat_expected[$];
  int    errors = 0;
  bit    idle_on = 1'b1;   // random gaps enabled
  int    hold_off = 0;     // long receiver stall request, in cycles

  always #4 clk = ~clk;

  rotation_matrix_to_quaternion uut (
    .clk(clk), .rst(rst),
    .mat_valid(mat_valid), .mat_ready(mat_ready), .mat(mat),
    .quat_valid(quat_valid), .quat_ready(quat_ready), .quat(quat)
  );

  // ---------------- predictor ----------------
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] sat16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return -16'sh8000;
    return v[15:0];
  endfunction

  // D / (2 sqrt R), rounded half away from zero
  function automatic logic signed [15:0] off_diag(longint d, longint unsigned s);
    longint unsigned mag, q;
    longint r;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    q = ((mag << FB) + s) / (2 * s);
    r = (q > 1000000) ? 1000000 : longint'(q);
    return sat16(d < 0 ? -r : r);
  endfunction

  function automatic quat_t shepperd(mat_t m);
    longint m00, m10, m20, m01, m11, m21, m02, m12, m22, tr, rad, d0, d1, d2;
    longint unsigned s;
    logic signed [15:0] big, c0, c1, c2;
    quat_t q;
    m00 = m.col0_x; m10 = m.col0_y; m20 = m.col0_z;
    m01 = m.col1_x; m11 = m.col1_y; m21 = m.col1_z;
    m02 = m.col2_x; m12 = m.col2_y; m22 = m.col2_z;
    tr = m00 + m11 + m22;
    q.radicand_clamped = 1'b0;
    if (tr > 0) begin
      q.branch_taken = BR_TRACE;
      rad = ONE + tr; d0 = m21 - m12; d1 = m02 - m20; d2 = m10 - m01;
    end else if (m00 > m11 && m00 > m22) begin
      q.branch_taken = BR_X;
      rad = ONE + m00 - m11 - m22; d0 = m01 + m10; d1 = m02 + m20; d2 = m21 - m12;
    end else if (m11 > m22) begin
      q.branch_taken = BR_Y;
      rad = ONE + m11 - m00 - m22; d0 = m01 + m10; d1 = m12 + m21; d2 = m02 - m20;
    end else begin
      q.branch_taken = BR_Z;
      rad = ONE + m22 - m00 - m11; d0 = m02 + m20; d1 = m12 + m21; d2 = m10 - m01;
    end
    // non-orthonormal input: radicand clamped to one LSB
    if (rad <= 0) begin
      rad = 1;
      q.radicand_clamped = 1'b1;
    end
    s = int_sqrt(longint'(rad) << FB);
    big = sat16(longint'((s + 1) >> 1));
    c0 = off_diag(d0, s);
    c1 = off_diag(d1, s);
    c2 = off_diag(d2, s);
    case (q.branch_taken)
      BR_TRACE: begin q.quat_x = c0;  q.quat_y = c1;  q.quat_z = c2;  q.quat_w = big; end
      BR_X:     begin q.quat_x = big; q.quat_y = c0;  q.quat_z = c1;  q.quat_w = c2;  end
      BR_Y:     begin q.quat_x = c0;  q.quat_y = big; q.quat_z = c1;  q.quat_w = c2;  end
      default:  begin q.quat_x = c0;  q.quat_y = c1;  q.quat_z = big; q.quat_w = c2;  end
    endcase
    return q;
  endfunction

  // ---------------- driver ----------------
  task automatic send_matrix(mat_t m);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      mat_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    mat_valid <= 1'b1;
    mat <= m;
    @(posedge clk);
    while (!mat_ready) @(posedge clk);
    quat_expected.push_back(shepperd(m));
  endtask

  task automatic drop_valid();
    mat_valid <= 1'b0;
  endtask

  // receiver: random stall bursts, plus an optional long hold-off
  initial begin
    int n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off > 0) begin
        n = hold_off;
        hold_off = 0;
        quat_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        quat_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        quat_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // checker: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    quat_t e;
    if (!rst && quat_valid && quat_ready) begin
      if (quat_expected.size() == 0) begin
        $display("%0t: unexpected result %h", $time, quat);
        errors++;
      end else begin
        e = quat_expected.pop_front();
        if (quat.quat_x !== e.quat_x)
          $display("%0t: quat_x exp %0d got %0d", $time, e.quat_x, quat.quat_x);
        if (quat.quat_y !== e.quat_y)
          $display("%0t: quat_y exp %0d got %0d", $time, e.quat_y, quat.quat_y);
        if (quat.quat_z !== e.quat_z)
          $display("%0t: quat_z exp %0d got %0d", $time, e.quat_z, quat.quat_z);
        if (quat.quat_w !== e.quat_w)
          $display("%0t: quat_w exp %0d got %0d", $time, e.quat_w, quat.quat_w);
        if (quat.branch_taken !== e.branch_taken)
          $display("%0t: branch exp %0d got %0d", $time, e.branch_taken,
                   quat.branch_taken);
        if (quat.radicand_clamped !== e.radicand_clamped)
          $display("%0t: clamp exp %0b got %0b", $time, e.radicand_clamped,
                   quat.radicand_clamped);
        if (quat !== e) errors++;
      end
    end
  end

  // ---------------- stimulus helpers ----------------
  function automatic mat_t diag_mat(int a, int b, int c);
    mat_t m;
    m = '0;
    m.col0_x = 16'(a); m.col1_y = 16'(b); m.col2_z = 16'(c);
    return m;
  endfunction

  function automatic mat_t random_mat();
    mat_t m;
    logic [159:0] r;
    r = {$urandom, $urandom, $urandom, $urandom, $urandom};
    m = r[143:0];
    return m;
  endfunction

  // rotation-like matrix: signed-permutation base plus small noise
  function automatic mat_t near_rotation();
    mat_t m;
    int p;
    m = '0;
    p = $urandom_range(0, 3);
    case (p)
      0: m = diag_mat(16384, 16384, 16384);
      1: m = diag_mat(16384, -16384, -16384);
      2: m = diag_mat(-16384, 16384, -16384);
      default: m = diag_mat(-16384, -16384, 16384);
    endcase
    m.col0_x = 16'(m.col0_x + ($signed($urandom_range(0, 8000)) - 4000));
    m.col1_y = 16'(m.col1_y + ($signed($urandom_range(0, 8000)) - 4000));
    m.col2_z = 16'(m.col2_z + ($signed($urandom_range(0, 8000)) - 4000));
    m.col0_y = 16'($signed($urandom_range(0, 16000)) - 8000);
    m.col0_z = 16'($signed($urandom_range(0, 16000)) - 8000);
    m.col1_x = 16'($signed($urandom_range(0, 16000)) - 8000);
    m.col1_z = 16'($signed($urandom_range(0, 16000)) - 8000);
    m.col2_x = 16'($signed($urandom_range(0, 16000)) - 8000);
    m.col2_y = 16'($signed($urandom_range(0, 16000)) - 8000);
    return m;
  endfunction

  // ---------------- tests ----------------
  task automatic test_branches();
    send_matrix(diag_mat(16384, 16384, 16384));     // identity, trace branch
    send_matrix(diag_mat(16384, -16384, -16384));   // x largest
    send_matrix(diag_mat(-16384, 16384, -16384));   // y largest
    send_matrix(diag_mat(-16384, -16384, 16384));   // z largest
    send_matrix(diag_mat(0, 0, 0));                 // zero trace, ties go to z
    send_matrix(diag_mat(-100, -100, -200));        // tie x and y -> y
    send_matrix(diag_mat(-100, -200, -100));        // tie x and z -> z
  endtask

  task automatic test_extremes();
    mat_t m;
    send_matrix('0);
    send_matrix('1);
    m = {9{16'sh7fff}};
    send_matrix(m);
    m = {9{16'sh8000}};
    send_matrix(m);                                 // all diagonal terms tie, z branch, radicand not clamped
    m = diag_mat(-32768, 32767, 32767);
    send_matrix(m);
    m = diag_mat(-32768, -32768, -32768);
    m.col0_y = 32767; m.col1_x = 32767;             // huge off-diagonals that cancel in the z branch
    send_matrix(m);
    m = diag_mat(32767, -32768, -32768);
    m.col1_x = -32768; m.col0_y = -32768; m.col2_x = 32767; m.col0_z = 32767;
    send_matrix(m);
    m = diag_mat(-30000, -30000, -1);               // z wins, radicand stays positive
    send_matrix(m);
  endtask

  task automatic test_random(int n);
    repeat (n) begin
      if ($urandom_range(0, 9) < 7) send_matrix(near_rotation());
      else send_matrix(random_mat());
    end
  endtask

  task automatic test_backpressure();
    hold_off = 300;
    repeat (40) send_matrix(near_rotation());
  endtask

  task automatic drain();
    drop_valid();
    while (quat_expected.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_branches();
    test_extremes();
    test_backpressure();
    test_random(330);
    // last part: no idling on either side
    idle_on = 1'b0;
    test_random(60);
    drain();
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
